// ===== hw/rtl/ecpi_pkg.sv =====
`timescale 1ns / 1ps

package ecpi_pkg;

  // Largest number of distinct colours the palette can hold.
  localparam int MaxColors = 255;
  // Width of a palette index and of the colour count.
  localparam int IdxW      = $clog2(MaxColors + 1);
  localparam int ChanW     = 8;
  localparam int ColorW    = 3 * ChanW;
  localparam int DepthW    = 4;

  // One pixel travelling down the cell chain.
  typedef struct packed {
    logic              valid;
    logic [ColorW-1:0] color;
    logic              resolved;  // matched or claimed a slot somewhere upstream
    logic [IdxW-1:0]   idx;
    logic [IdxW-1:0]   cnt;       // colours stored once this pixel has been placed
  } pkt_t;

  // Smallest d >= 1 with 2^d >= count + 1, limited to IdxW bits.
  function automatic logic [DepthW-1:0] depth_for(logic [IdxW-1:0] count);
    logic [IdxW:0]     need;
    logic [DepthW-1:0] d;
    need = {1'b0, count} + (IdxW + 1)'(1);
    d    = DepthW'(1);
    for (int k = 1; k < IdxW; k++) begin
      if (((IdxW + 1)'(1) << k) < need) begin
        d = DepthW'(k + 1);
      end
    end
    return d;
  endfunction

endpackage

// ===== hw/rtl/ecpi_cell.sv =====
`timescale 1ns / 1ps

// One palette slot plus one pipeline stage of the search.
module ecpi_cell (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       adv,
  input  logic [ecpi_pkg::IdxW-1:0]  count,
  input  logic [ecpi_pkg::IdxW-1:0]  cell_idx,
  input  ecpi_pkg::pkt_t             pkt_in,
  output ecpi_pkg::pkt_t             pkt_out,
  output logic                       claim
);

  logic [ecpi_pkg::ColorW-1:0] entry_r;
  ecpi_pkg::pkt_t              pkt_r;
  ecpi_pkg::pkt_t              pkt_nxt;
  logic                        occupied;
  logic                        live;
  logic                        hit;
  logic                        grab;

  // Slots fill strictly in order, so the count says which ones hold a colour.
  assign occupied = cell_idx < count;
  assign live     = pkt_in.valid && !pkt_in.resolved;
  assign hit      = live && occupied && (entry_r == pkt_in.color);
  assign grab     = live && (cell_idx == count);
  assign claim    = grab && adv;

  always_comb begin
    pkt_nxt = pkt_in;
    if (hit || grab) begin
      pkt_nxt.resolved = 1'b1;
      pkt_nxt.idx      = cell_idx;
    end
    if (occupied || grab) begin
      pkt_nxt.cnt = cell_idx + ecpi_pkg::IdxW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_r.valid <= 1'b0;
    end else if (adv) begin
      pkt_r <= pkt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (claim) begin
      entry_r <= pkt_in.color;
    end
  end

  assign pkt_out = pkt_r;

endmodule

// ===== hw/rtl/ecpi_chain.sv =====
`timescale 1ns / 1ps

// Row of palette cells and the shared fill count.
module ecpi_chain (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      adv,
  input  ecpi_pkg::pkt_t            pkt_in,
  output ecpi_pkg::pkt_t            pkt_out
);

  ecpi_pkg::pkt_t                    pkt_w [0:ecpi_pkg::MaxColors];
  logic [ecpi_pkg::MaxColors-1:0]    claim_w;
  logic [ecpi_pkg::IdxW-1:0]         count_r;
  logic [ecpi_pkg::IdxW-1:0]         count_nxt;

  assign pkt_w[0] = pkt_in;

  for (genvar i = 0; i < ecpi_pkg::MaxColors; i++) begin : g_cell
    ecpi_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .adv      (adv),
      .count    (count_r),
      .cell_idx (ecpi_pkg::IdxW'(i)),
      .pkt_in   (pkt_w[i]),
      .pkt_out  (pkt_w[i+1]),
      .claim    (claim_w[i])
    );
  end

  // Only the cell at the fill position can claim, so at most one bit is set.
  assign count_nxt = (|claim_w) ? count_r + ecpi_pkg::IdxW'(1) : count_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
  end

  assign pkt_out = pkt_w[ecpi_pkg::MaxColors];

endmodule

// ===== hw/rtl/ecpi_out.sv =====
`timescale 1ns / 1ps

// Result register with the sticky overflow flag and depth calculation.
module ecpi_out (
  input  logic                          clk,
  input  logic                          rst_n,
  input  ecpi_pkg::pkt_t                pkt_in,
  input  logic                          out_ready,
  output logic                          adv,
  output logic                          out_valid,
  output logic [ecpi_pkg::IdxW-1:0]     out_color_index,
  output logic                          out_overflow,
  output logic [ecpi_pkg::IdxW-1:0]     out_color_count,
  output logic [ecpi_pkg::DepthW-1:0]   out_depth_bits
);

  logic                          valid_r;
  logic                          sticky_r;
  logic                          sticky_nxt;
  logic                          flag;
  logic [ecpi_pkg::IdxW-1:0]     index_r;
  logic                          ovf_r;
  logic [ecpi_pkg::IdxW-1:0]     count_r;
  logic [ecpi_pkg::DepthW-1:0]   depth_r;

  assign adv = !valid_r || out_ready;

  // A pixel that leaves the chain unplaced found the palette full.
  assign flag       = sticky_r || (pkt_in.valid && !pkt_in.resolved);
  assign sticky_nxt = (adv && pkt_in.valid) ? flag : sticky_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r  <= 1'b0;
      sticky_r <= 1'b0;
    end else begin
      sticky_r <= sticky_nxt;
      if (adv) begin
        valid_r <= pkt_in.valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      index_r <= flag ? '0 : pkt_in.idx;
      ovf_r   <= flag;
      count_r <= pkt_in.cnt;
      depth_r <= ecpi_pkg::depth_for(pkt_in.cnt);
    end
  end

  assign out_valid       = valid_r;
  assign out_color_index = index_r;
  assign out_overflow    = ovf_r;
  assign out_color_count = count_r;
  assign out_depth_bits  = depth_r;

endmodule

// ===== hw/rtl/exact_color_palette_indexer_top.sv =====
`timescale 1ns / 1ps

// Exact colour palette indexer. Each input beat is one RGB pixel; each output beat gives the
// palette index of that colour, the sticky overflow flag, the number of colours stored after
// the pixel and the index depth needed for that count plus one. Colours are kept in order of
// first appearance in a row of 255 cells, one colour per cell. A pixel walks down the row one
// cell per clock, comparing against each stored colour, and claims the first empty cell if it
// finds no match. Pixels follow one another a cell apart, so while the row is not stalled the
// block takes a new pixel every clock. The first cell registers a pixel at the edge that takes
// it; the pixel then passes through the register of each cell in turn, and the output register
// picks its result up from the last cell. The whole row advances together: when the output
// register holds a beat that has not been taken, the row and the input stall. Once a new
// colour arrives with the palette full, that result and every later one carry overflow set
// and index zero, until reset. Reset is synchronous; no clearing pass is needed.
module exact_color_palette_indexer_top (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [ecpi_pkg::ChanW-1:0]    in_red,
  input  logic [ecpi_pkg::ChanW-1:0]    in_green,
  input  logic [ecpi_pkg::ChanW-1:0]    in_blue,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [ecpi_pkg::IdxW-1:0]     out_color_index,
  output logic                          out_overflow,
  output logic [ecpi_pkg::IdxW-1:0]     out_color_count,
  output logic [ecpi_pkg::DepthW-1:0]   out_depth_bits
);

  logic           adv;
  ecpi_pkg::pkt_t head_pkt;
  ecpi_pkg::pkt_t tail_pkt;

  // A fresh pixel enters unresolved with nothing counted yet.
  always_comb begin
    head_pkt          = '0;
    head_pkt.valid    = in_valid;
    head_pkt.color    = {in_red, in_green, in_blue};
    head_pkt.resolved = 1'b0;
  end

  // The chain shifts exactly when the output register can take its last stage.
  assign in_ready = adv;

  ecpi_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .adv     (adv),
    .pkt_in  (head_pkt),
    .pkt_out (tail_pkt)
  );

  ecpi_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .pkt_in          (tail_pkt),
    .out_ready       (out_ready),
    .adv             (adv),
    .out_valid       (out_valid),
    .out_color_index (out_color_index),
    .out_overflow    (out_overflow),
    .out_color_count (out_color_count),
    .out_depth_bits  (out_depth_bits)
  );

endmodule

// ===== bench/exact_color_palette_indexer_top_tb.sv =====
`timescale 1ns / 1ps

module exact_color_palette_indexer_top_tb;

  // Run shape. The random phase lets the palette grow to a ceiling well short of full. The
  // final test then fills the palette on purpose and pushes it into overflow, because
  // overflow is sticky until reset and reset is only applied once.
  localparam int RandomPixels       = 420;
  localparam int BackpressurePixels = 300;
  localparam int AfterOverflowBeats = 30;
  localparam int GrowthCeiling      = 200;
  // The block holds 255 cells plus an output register, so a hold-off longer than that lets a
  // beat reach the held output register, which must push back on the input.
  localparam int LongHoldCycles     = 400;
  // A result appears once its pixel has passed every cell and the output register; add a margin.
  localparam int DrainCycles        = 300;
  localparam int ReportLimit        = 10;

  typedef struct packed {
    logic [ecpi_pkg::IdxW-1:0]   color_index;
    logic                        overflow;
    logic [ecpi_pkg::IdxW-1:0]   color_count;
    logic [ecpi_pkg::DepthW-1:0] depth_bits;
  } pixel_result_t;

  // Every input of the block has a known value from time zero.
  logic                        clk       = 1'b0;
  logic                        rst_n     = 1'b0;
  logic                        in_valid  = 1'b0;
  logic [ecpi_pkg::ChanW-1:0]  in_red    = '0;
  logic [ecpi_pkg::ChanW-1:0]  in_green  = '0;
  logic [ecpi_pkg::ChanW-1:0]  in_blue   = '0;
  logic                        out_ready = 1'b0;
  logic                        in_ready;
  logic                        out_valid;
  logic [ecpi_pkg::IdxW-1:0]   out_color_index;
  logic                        out_overflow;
  logic [ecpi_pkg::IdxW-1:0]   out_color_count;
  logic [ecpi_pkg::DepthW-1:0] out_depth_bits;

  // The testbench's own copy of the palette, in order of first appearance.
  logic [ecpi_pkg::ColorW-1:0] palette_colors [ecpi_pkg::MaxColors];
  int unsigned       colors_stored;
  bit                palette_overflowed;

  // Results still owed by the block, oldest first.
  pixel_result_t     owed_results [$];

  int unsigned       pixels_sent;
  int unsigned       results_checked;
  int unsigned       mismatch_count;
  int unsigned       input_stall_cycles;

  // Set for the last part of the run, where neither side idles.
  bit                quiet_tail;
  // The main sequence raises this to ask the receiver for one long hold-off.
  bit                hold_request;
  int unsigned       sink_hold;

  always #5 clk = ~clk;

  exact_color_palette_indexer_top i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_red          (in_red),
    .in_green        (in_green),
    .in_blue         (in_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_color_index (out_color_index),
    .out_overflow    (out_overflow),
    .out_color_count (out_color_count),
    .out_depth_bits  (out_depth_bits)
  );

  // Slot of a colour in the palette, or -1 when it has not been stored yet. Only slots
  // below the current count are looked at, so an entry that was never written is never read.
  function automatic int palette_slot(logic [ecpi_pkg::ColorW-1:0] color);
    for (int p = 0; p < int'(colors_stored); p++) begin
      if (palette_colors[p] == color) begin
        return p;
      end
    end
    return -1;
  endfunction

  // Fewest index bits, never below one, that can name count plus one colours.
  function automatic logic [ecpi_pkg::DepthW-1:0] index_bits_for(int unsigned count);
    int unsigned d;
    d = 1;
    while (d < ecpi_pkg::IdxW && (1 << d) < count + 1) begin
      d++;
    end
    return ecpi_pkg::DepthW'(d);
  endfunction

  // Looks up one pixel, grows the palette if the colour is new, and returns the result
  // the block owes for it. A new colour with the palette full raises the sticky overflow;
  // from then on the index is zero and the palette no longer changes.
  function automatic pixel_result_t index_pixel(logic [ecpi_pkg::ColorW-1:0] color);
    pixel_result_t res;
    int            slot;
    res.color_index = '0;
    if (!palette_overflowed) begin
      slot = palette_slot(color);
      if (slot >= 0) begin
        res.color_index = ecpi_pkg::IdxW'(slot);
      end else if (colors_stored < ecpi_pkg::MaxColors) begin
        palette_colors[colors_stored] = color;
        res.color_index = ecpi_pkg::IdxW'(colors_stored);
        colors_stored++;
      end else begin
        palette_overflowed = 1'b1;
      end
    end
    res.overflow    = palette_overflowed;
    res.color_count = ecpi_pkg::IdxW'(colors_stored);
    res.depth_bits  = index_bits_for(colors_stored);
    return res;
  endfunction

  function automatic logic [ecpi_pkg::ChanW-1:0] corner_channel();
    case ($urandom_range(0, 2))
      0:       return '0;
      1:       return '1;
      default: return ecpi_pkg::ChanW'($urandom);
    endcase
  endfunction

  // Random pixel for the mixed phases. Half of the pixels repeat a stored colour, and a
  // fifth are a stored colour with one bit flipped, which is the nearest miss the compare
  // chain can see. The rest are fully random colours or colours whose channels are each zero, full or random.
  // Once the palette has reached the ceiling, any colour that would be new is swapped for a
  // stored one so that the overflow test keeps the filling of the last slots to itself.
  function automatic logic [ecpi_pkg::ColorW-1:0] pick_color();
    logic [ecpi_pkg::ColorW-1:0] c;
    int unsigned                 kind;
    kind = $urandom_range(0, 9);
    if (colors_stored == 0 || kind == 5 || kind == 6) begin
      c = ecpi_pkg::ColorW'($urandom);
    end else if (kind <= 4) begin
      c = palette_colors[$urandom_range(0, colors_stored - 1)];
    end else if (kind <= 8) begin
      c = palette_colors[$urandom_range(0, colors_stored - 1)];
      c = c ^ (ecpi_pkg::ColorW'(1) << $urandom_range(0, ecpi_pkg::ColorW - 1));
    end else begin
      c = {corner_channel(), corner_channel(), corner_channel()};
    end
    if (colors_stored >= GrowthCeiling && palette_slot(c) < 0) begin
      c = palette_colors[$urandom_range(0, colors_stored - 1)];
    end
    return c;
  endfunction

  // Offers one pixel and waits for its beat. Outside the quiet tail, the sender sometimes
  // drops valid for a short burst before the offer. Once valid is up it stays up, with the
  // payload held, until in_ready is seen high at an edge. The result is worked out at
  // that edge, so the order of expectations is the order of acceptance.
  task automatic send_pixel(input logic [ecpi_pkg::ColorW-1:0] color);
    if (!quiet_tail && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    {in_red, in_green, in_blue} <= color;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    owed_results.push_back(index_pixel(color));
    pixels_sent++;
  endtask

  // Black and white, each primary at full and half scale, the smallest and largest steps
  // away from black and white, and repeats of earlier colours. The count runs through
  // 1, 2, 4 and 8 here, so the depth moves from one bit up to four.
  task automatic test_directed_corners();
    logic [ecpi_pkg::ColorW-1:0] corners [20] = '{
      24'h000000, 24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'hFF0000,
      24'h00FF00, 24'h0000FF, 24'h800000, 24'h008000, 24'h000080,
      24'h000001, 24'hFFFFFE, 24'h010101, 24'h7F7F7F, 24'hFEFEFE,
      24'hFF0000, 24'h0000FF, 24'h000000, 24'hFFFFFE, 24'h000001
    };
    foreach (corners[k]) begin
      send_pixel(corners[k]);
    end
  endtask

  task automatic test_random_pixels();
    repeat (RandomPixels) begin
      send_pixel(pick_color());
    end
  endtask

  // The receiver holds off for a long stretch while the sender keeps offering pixels. Once the
  // output register holds a beat that has not been taken, the cell chain stalls, and in_ready
  // must fall until the receiver lets go again.
  task automatic test_output_backpressure();
    hold_request = 1'b1;
    repeat (BackpressurePixels) begin
      send_pixel(pick_color());
    end
  endtask

  // With no idling on either side, the palette is filled with fresh colours up to its last
  // slot, so the count reaches 255 and the depth eight bits. One more new colour must raise
  // overflow. After that, known and new colours alike must give index zero with the flag set.
  task automatic test_palette_overflow();
    logic [ecpi_pkg::ColorW-1:0] c;
    quiet_tail = 1'b1;
    while (colors_stored < ecpi_pkg::MaxColors) begin
      c = ecpi_pkg::ColorW'($urandom);
      if (palette_slot(c) < 0) begin
        send_pixel(c);
      end
    end
    do begin
      c = ecpi_pkg::ColorW'($urandom);
    end while (palette_slot(c) >= 0);
    send_pixel(c);
    send_pixel(c);
    send_pixel(palette_colors[0]);
    send_pixel(palette_colors[ecpi_pkg::MaxColors - 1]);
    repeat (AfterOverflowBeats) begin
      if ($urandom_range(0, 1) == 0) begin
        send_pixel(palette_colors[$urandom_range(0, ecpi_pkg::MaxColors - 1)]);
      end else begin
        send_pixel(ecpi_pkg::ColorW'($urandom));
      end
    end
  endtask

  // Receiver. A long hold-off, when asked for, is counted down here. Otherwise, outside the
  // quiet tail, ready drops now and then for a random burst.
  always @(posedge clk) begin
    if (hold_request) begin
      hold_request = 1'b0;
      sink_hold    = LongHoldCycles;
    end else if (sink_hold == 0 && !quiet_tail && $urandom_range(0, 5) == 0) begin
      sink_hold = $urandom_range(1, 6);
    end
    if (sink_hold != 0) begin
      out_ready <= 1'b0;
      sink_hold--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Checks each result beat against the oldest owed result. Values are those from just
  // before the edge, so the check does not depend on the order of processes in a step.
  always @(posedge clk) begin : check_results
    pixel_result_t want;
    if (rst_n && in_valid && !in_ready) begin
      input_stall_cycles++;
    end
    if (rst_n && out_valid && out_ready) begin
      if (owed_results.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= ReportLimit) begin
          $display("%0t: result beat with none owed: index %0d overflow %0b count %0d depth %0d",
                   $realtime, out_color_index, out_overflow, out_color_count, out_depth_bits);
        end
      end else begin
        want = owed_results.pop_front();
        results_checked++;
        if (out_color_index !== want.color_index || out_overflow !== want.overflow ||
            out_color_count !== want.color_count || out_depth_bits !== want.depth_bits) begin
          mismatch_count++;
          if (mismatch_count <= ReportLimit) begin
            $display("%0t: result %0d expected index %0d overflow %0b count %0d depth %0d",
                     $realtime, results_checked, want.color_index, want.overflow,
                     want.color_count, want.depth_bits);
            $display("%0t: result %0d got      index %0d overflow %0b count %0d depth %0d",
                     $realtime, results_checked, out_color_index, out_overflow,
                     out_color_count, out_depth_bits);
          end
        end
      end
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_directed_corners();
    test_random_pixels();
    test_output_backpressure();
    test_palette_overflow();
    in_valid <= 1'b0;

    // Let every owed result come out, then watch a while longer for stray beats.
    while (owed_results.size() != 0) begin
      @(posedge clk);
    end
    repeat (DrainCycles) @(posedge clk);

    $display("Sent %0d pixels and checked %0d results; the palette filled to %0d colours%s.",
             pixels_sent, results_checked, colors_stored,
             palette_overflowed ? " and went into overflow" : "");
    $display("Input was held back for %0d cycles in all; %0d result beats were wrong or unowed.",
             input_stall_cycles, mismatch_count);
    if (mismatch_count == 0 && owed_results.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Far beyond the slowest correct run, with every beat waiting out the longest gaps.
  initial begin
    #5ms;
    $display("Timed out with %0d results still owed.", owed_results.size());
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule

// ===== exact_color_palette_indexer_top.f =====
hw/rtl/ecpi_pkg.sv
hw/rtl/ecpi_cell.sv
hw/rtl/ecpi_chain.sv
hw/rtl/ecpi_out.sv
hw/rtl/exact_color_palette_indexer_top.sv
bench/exact_color_palette_indexer_top_tb.sv
